/* rtl/alhm_pkg.sv */
`timescale 1ns / 1ps
package alhm_pkg;
  localparam int LANES_DEF = 8;
  localparam int FLAP_SLOTS_DEF = 3;
  localparam int STORM_SLOTS_DEF = 4;

  localparam logic [1:0] ST_AVAIL = 2'd0;
  localparam logic [1:0] ST_UNAVAIL = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [2:0] HS_OK = 3'd0;
  localparam logic [2:0] HS_NO_DATA = 3'd1;
  localparam logic [2:0] HS_BUS_ERR = 3'd4;
  localparam logic [2:0] HS_HW_FAULT = 3'd5;

  localparam logic [2:0] CFG_FLAP_WIN = 3'd0;
  localparam logic [2:0] CFG_FLAP_MAX = 3'd1;
  localparam logic [2:0] CFG_STORM_WIN = 3'd2;
  localparam logic [2:0] CFG_STORM_THR = 3'd3;
  localparam logic [2:0] CFG_DC_THR = 3'd4;
  localparam logic [2:0] CFG_DC_HOLD = 3'd5;

  typedef struct packed {
    logic load;
    logic compute;
    logic commit;
  } alhm_cmd_t;
endpackage

/* rtl/alhm_ctrl.sv */
`timescale 1ns / 1ps
module alhm_ctrl
  import alhm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output alhm_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_COMMIT = 4'b0100,
    S_OUT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CALC;
      S_CALC: state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_OUT;
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load = in_valid && in_ready;
  assign cmd.compute = (state_r == S_CALC);
  assign cmd.commit = (state_r == S_COMMIT);
endmodule

/* rtl/alhm_dp.sv */
`timescale 1ns / 1ps
module alhm_dp
  import alhm_pkg::*;
#(
  parameter int LANES = LANES_DEF,
  parameter int FLAP_SLOTS = FLAP_SLOTS_DEF,
  parameter int STORM_SLOTS = STORM_SLOTS_DEF,
  localparam int LW = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  alhm_cmd_t         cmd,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [21:0]       cfg_wdata,
  input  logic [LW-1:0]     in_lane,
  input  logic              in_mapped,
  input  logic [31:0]       in_now_ms,
  input  logic [2:0]        in_health_status,
  input  logic [1:0]        in_device_state,
  input  logic [31:0]       in_recovery_counter,
  input  logic signed [15:0] in_dc_offset,
  output logic [1:0]        out_new_state,
  output logic              out_health_fail,
  output logic              out_adc_recovered,
  output logic              out_flapping,
  output logic              out_recovery_storm,
  output logic              out_pipeline_stall,
  output logic              out_dc_offset_high
);
  localparam int LIW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int FCW = $clog2(FLAP_SLOTS + 1);
  localparam int SCW = $clog2(STORM_SLOTS + 1);

  logic [21:0] flap_win_r, storm_win_r;
  logic [1:0] flap_max_r, storm_thr_r;
  logic [14:0] dc_thr_r;
  logic [7:0] dc_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flap_win_r <= 22'd30000;
      flap_max_r <= 2'd2;
      storm_win_r <= 22'd60000;
      storm_thr_r <= 2'd3;
      dc_thr_r <= 15'd1638;
      dc_hold_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLAP_WIN: flap_win_r <= cfg_wdata;
        CFG_FLAP_MAX: flap_max_r <= cfg_wdata[1:0];
        CFG_STORM_WIN: storm_win_r <= cfg_wdata;
        CFG_STORM_THR: storm_thr_r <= cfg_wdata[1:0];
        CFG_DC_THR: dc_thr_r <= cfg_wdata[14:0];
        CFG_DC_HOLD: dc_hold_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic [31:0] flap_t_r [LANES][FLAP_SLOTS];
  logic [FCW-1:0] flap_c_r [LANES];
  logic [31:0] last_rc_r [LANES];
  logic [31:0] storm_t_r [LANES][STORM_SLOTS];
  logic [SCW-1:0] storm_c_r [LANES];
  logic [7:0] stall_c_r [LANES];
  logic [7:0] dc_c_r [LANES];

  // Latched item.
  logic [LIW-1:0] lane_r;
  logic act_r;
  logic [31:0] now_r, rc_r;
  logic [2:0] hs_r;
  logic [1:0] st_r;
  logic signed [15:0] dc_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lane_r <= LIW'(in_lane);
      act_r <= in_mapped && (32'(in_lane) < LANES);
      now_r <= in_now_ms;
      rc_r <= in_recovery_counter;
      hs_r <= in_health_status;
      st_r <= in_device_state;
      dc_r <= in_dc_offset;
    end
  end

  // Stage one: read lane state, compute cutoffs and per-slot keep bits.
  logic [31:0] fcut, scut;
  assign fcut = (now_r >= {10'd0, flap_win_r}) ? now_r - {10'd0, flap_win_r} : 32'd0;
  assign scut = (now_r >= {10'd0, storm_win_r}) ? now_r - {10'd0, storm_win_r} : 32'd0;

  logic [31:0] ft_r [FLAP_SLOTS];
  logic [31:0] stt_r [STORM_SLOTS];
  logic [FLAP_SLOTS-1:0] fkeep_r;
  logic [STORM_SLOTS-1:0] skeep_r;
  logic rc_chg_r;
  logic [7:0] stallc_r, dcc_r;

  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      for (int i = 0; i < FLAP_SLOTS; i++) begin
        ft_r[i] <= flap_t_r[lane_r][i];
        fkeep_r[i] <= (32'(i) < 32'(flap_c_r[lane_r])) && (flap_t_r[lane_r][i] >= fcut);
      end
      for (int i = 0; i < STORM_SLOTS; i++) begin
        stt_r[i] <= storm_t_r[lane_r][i];
        skeep_r[i] <= (32'(i) < 32'(storm_c_r[lane_r])) && (storm_t_r[lane_r][i] >= scut);
      end
      rc_chg_r <= rc_r != last_rc_r[lane_r];
      stallc_r <= stall_c_r[lane_r];
      dcc_r <= dc_c_r[lane_r];
    end
  end

  // Stage two: compaction and flags.
  logic fault, changed, fail, recov;
  logic [1:0] st1;
  logic [31:0] fnew [FLAP_SLOTS];
  logic [31:0] snew [STORM_SLOTS];
  logic [FCW-1:0] fcnt;
  logic [SCW-1:0] scnt;
  logic [1:0] st2;
  logic flap, storm, stall, dch, dc_hi;
  logic [7:0] stall_n, dc_n;

  always_comb begin
    fault = (hs_r == HS_BUS_ERR) || (hs_r == HS_HW_FAULT);
    fail = fault && (st_r == ST_AVAIL);
    recov = !fail && (hs_r == HS_OK) && (st_r == ST_UNAVAIL);
    changed = fail || recov;
    st1 = fail ? ST_UNAVAIL : (recov ? ST_AVAIL : st_r);
    fcnt = '0;
    for (int i = 0; i < FLAP_SLOTS; i++) fnew[i] = ft_r[i];
    for (int i = 0; i < FLAP_SLOTS; i++) begin
      if (fkeep_r[i]) begin
        for (int j = 0; j < FLAP_SLOTS; j++) begin
          if (32'(j) == 32'(fcnt)) fnew[j] = ft_r[i];
        end
        fcnt = fcnt + 1'b1;
      end
    end
    if (32'(fcnt) < FLAP_SLOTS) begin
      for (int j = 0; j < FLAP_SLOTS; j++) begin
        if (32'(j) == 32'(fcnt)) fnew[j] = now_r;
      end
      fcnt = fcnt + 1'b1;
    end else begin
      for (int i = 0; i + 1 < FLAP_SLOTS; i++) fnew[i] = fnew[i + 1];
      fnew[FLAP_SLOTS - 1] = now_r;
    end
    scnt = '0;
    for (int i = 0; i < STORM_SLOTS; i++) snew[i] = stt_r[i];
    for (int i = 0; i < STORM_SLOTS; i++) begin
      if (skeep_r[i]) begin
        for (int j = 0; j < STORM_SLOTS; j++) begin
          if (32'(j) == 32'(scnt)) snew[j] = stt_r[i];
        end
        scnt = scnt + 1'b1;
      end
    end
    if (32'(scnt) < STORM_SLOTS) begin
      for (int j = 0; j < STORM_SLOTS; j++) begin
        if (32'(j) == 32'(scnt)) snew[j] = now_r;
      end
      scnt = scnt + 1'b1;
    end else begin
      for (int i = 0; i + 1 < STORM_SLOTS; i++) snew[i] = snew[i + 1];
      snew[STORM_SLOTS - 1] = now_r;
    end
    flap = changed && (32'(fcnt) > 32'(flap_max_r));
    st2 = flap ? ST_ERROR : st1;
    storm = rc_chg_r && (32'(scnt) > 32'(storm_thr_r));
    stall = 1'b0;
    stall_n = 8'd0;
    if ((hs_r == HS_NO_DATA) && (st2 == ST_AVAIL)) begin
      stall = (stallc_r == 8'd0);
      stall_n = (stallc_r != 8'd255) ? stallc_r + 8'd1 : stallc_r;
    end
    dc_hi = 32'(signed'(dc_r)) > signed'({17'd0, dc_thr_r});
    dch = 1'b0;
    dc_n = 8'd0;
    if (dc_hi) begin
      dc_n = dcc_r;
      if (dcc_r != 8'd255) begin
        dc_n = dcc_r + 8'd1;
        dch = ({1'b0, dc_n} == {1'b0, dc_hold_r} + 9'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANES; l++) begin
        flap_c_r[l] <= '0;
        storm_c_r[l] <= '0;
        last_rc_r[l] <= '0;
        stall_c_r[l] <= '0;
        dc_c_r[l] <= '0;
        for (int i = 0; i < FLAP_SLOTS; i++) flap_t_r[l][i] <= '0;
        for (int i = 0; i < STORM_SLOTS; i++) storm_t_r[l][i] <= '0;
      end
    end else if (cmd.commit && act_r) begin
      if (changed) begin
        flap_c_r[lane_r] <= fcnt;
        for (int i = 0; i < FLAP_SLOTS; i++) flap_t_r[lane_r][i] <= fnew[i];
      end
      if (rc_chg_r) begin
        storm_c_r[lane_r] <= scnt;
        last_rc_r[lane_r] <= rc_r;
        for (int i = 0; i < STORM_SLOTS; i++) storm_t_r[lane_r][i] <= snew[i];
      end
      stall_c_r[lane_r] <= stall_n;
      dc_c_r[lane_r] <= dc_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_new_state <= act_r ? st2 : st_r;
      out_health_fail <= act_r && fail;
      out_adc_recovered <= act_r && recov;
      out_flapping <= act_r && flap;
      out_recovery_storm <= act_r && storm;
      out_pipeline_stall <= act_r && stall;
      out_dc_offset_high <= act_r && dch;
    end
  end
endmodule

/* rtl/audio_lane_health_monitor_top.sv */
`timescale 1ns / 1ps
// Sequence: an accepted check passes through the calc and commit states, and its
// result is then held in the output state until out_ready; the block holds one
// check at a time in a small sequencer and takes no new check until the result goes.
// Reset: synchronous active-low rst_n clears all lane history to zero and loads
// the default configuration values.
module audio_lane_health_monitor_top
  import alhm_pkg::*;
#(
  parameter int LANES = LANES_DEF,
  parameter int FLAP_SLOTS = FLAP_SLOTS_DEF,
  parameter int STORM_SLOTS = STORM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [21:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_lane,
  input  logic              in_mapped,
  input  logic [31:0]       in_now_ms,
  input  logic [2:0]        in_health_status,
  input  logic [1:0]        in_device_state,
  input  logic [31:0]       in_recovery_counter,
  input  logic signed [15:0] in_dc_offset,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_new_state,
  output logic              out_health_fail,
  output logic              out_adc_recovered,
  output logic              out_flapping,
  output logic              out_recovery_storm,
  output logic              out_pipeline_stall,
  output logic              out_dc_offset_high
);
  alhm_cmd_t cmd;

  // The controller sequences load, compute, commit and result transfer.
  alhm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
  );

  // The datapath holds per-lane windows and counters and forms the result.
  alhm_dp #(.LANES(LANES), .FLAP_SLOTS(FLAP_SLOTS), .STORM_SLOTS(STORM_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_lane(in_lane), .in_mapped(in_mapped), .in_now_ms(in_now_ms),
    .in_health_status(in_health_status), .in_device_state(in_device_state),
    .in_recovery_counter(in_recovery_counter), .in_dc_offset(in_dc_offset),
    .out_new_state(out_new_state), .out_health_fail(out_health_fail),
    .out_adc_recovered(out_adc_recovered), .out_flapping(out_flapping),
    .out_recovery_storm(out_recovery_storm), .out_pipeline_stall(out_pipeline_stall),
    .out_dc_offset_high(out_dc_offset_high)
  );

  // A check is never taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input ready while result pending");
  // An accepted transfer yields a result after the calc and commit states.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##2 out_valid)
    else $error("result did not appear");
  // A flapping device always reports the error state.
  a_flap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flapping) |-> (out_new_state == ST_ERROR))
    else $error("flap without error state");
endmodule
